[design/script_token_lexer_defines.svh]
// assertion helpers for the script token lexer
`ifndef SCRIPT_TOKEN_LEXER_DEFINES_SVH
`define SCRIPT_TOKEN_LEXER_DEFINES_SVH

// condition holds at every clock edge outside reset
`define STL_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("lexer check failed");

// antecedent implies consequent in the next cycle
`define STL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer check failed");

`endif

[design/stl_pkg.sv]
// ----------------------------------------------------------------------------
// stl_pkg
// Types, token codes and the keyword table of the script token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_source;
  } stl_in_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic [1:0]  error_kind;
    logic        last_of_run;
  } stl_tok_t;

  // token codes
  localparam logic [5:0] K_LPAREN  = 6'd0;
  localparam logic [5:0] K_RPAREN  = 6'd1;
  localparam logic [5:0] K_LBRACE  = 6'd2;
  localparam logic [5:0] K_RBRACE  = 6'd3;
  localparam logic [5:0] K_COMMA   = 6'd4;
  localparam logic [5:0] K_DOT     = 6'd5;
  localparam logic [5:0] K_MINUS   = 6'd6;
  localparam logic [5:0] K_PLUS    = 6'd7;
  localparam logic [5:0] K_SEMI    = 6'd8;
  localparam logic [5:0] K_SLASH   = 6'd9;
  localparam logic [5:0] K_STAR    = 6'd10;
  localparam logic [5:0] K_BANG    = 6'd11;
  localparam logic [5:0] K_EQUAL   = 6'd13;
  localparam logic [5:0] K_GREATER = 6'd15;
  localparam logic [5:0] K_LESS    = 6'd17;
  localparam logic [5:0] K_IDENT   = 6'd19;
  localparam logic [5:0] K_STRING  = 6'd20;
  localparam logic [5:0] K_NUMBER  = 6'd21;
  localparam logic [5:0] K_KW_BASE = 6'd22;
  localparam logic [5:0] K_ERROR   = 6'd38;
  localparam logic [5:0] K_EOF     = 6'd39;

  localparam logic [1:0] E_NONE  = 2'd0;
  localparam logic [1:0] E_CHAR  = 2'd1;
  localparam logic [1:0] E_UNTERM = 2'd2;

  localparam int PREFIX_DEPTH = 6;

  typedef enum logic [8:0] {
    M_IDLE       = 9'b000000001,
    M_IDENT      = 9'b000000010,
    M_NUMBER     = 9'b000000100,
    M_NUM_DOT    = 9'b000001000,
    M_FRACTION   = 9'b000010000,
    M_STRING     = 9'b000100000,
    M_HELD_OP    = 9'b001000000,
    M_HELD_SLASH = 9'b010000000,
    M_COMMENT    = 9'b100000000
  } stl_mode_t;

  localparam logic [7:0] KW_CHR [16][PREFIX_DEPTH] = '{
    '{"a", "n", "d", 8'h00, 8'h00, 8'h00},
    '{"c", "l", "a", "s", "s", 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00},
    '{"f", "a", "l", "s", "e", 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
    '{"f", "u", "n", 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"n", "i", "l", 8'h00, 8'h00, 8'h00},
    '{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "r", "i", "n", "t", 8'h00},
    '{"r", "e", "t", "u", "r", "n"},
    '{"s", "u", "p", "e", "r", 8'h00},
    '{"t", "h", "i", "s", 8'h00, 8'h00},
    '{"t", "r", "u", "e", 8'h00, 8'h00},
    '{"v", "a", "r", 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00}
  };
  localparam logic [2:0] KW_LEN [16] = '{
    3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
    3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
  };

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // keyword match over the stored word prefix
  function automatic logic [5:0] word_kind(input logic [7:0] pre [PREFIX_DEPTH],
                                           input logic [2:0] len);
    logic [5:0] kind;
    logic       hit;
    kind = K_IDENT;
    for (int k = 15; k >= 0; k--) begin
      hit = (KW_LEN[k] == len);
      for (int i = 0; i < PREFIX_DEPTH; i++) begin
        if (3'(i) < len && pre[i] != KW_CHR[k][i]) hit = 1'b0;
      end
      if (hit) kind = K_KW_BASE + 6'(k);
    end
    return kind;
  endfunction

  function automatic logic [5:0] op_kind(input logic [7:0] c, input logic two);
    logic [5:0] base;
    case (c)
      "=":     base = K_EQUAL;
      ">":     base = K_GREATER;
      "<":     base = K_LESS;
      default: base = K_BANG;
    endcase
    return two ? base + 6'd1 : base;
  endfunction

endpackage

[design/script_token_lexer.sv]
// A token appears on out_ in the cycle after the byte that closes it is accepted.
// Throughput: one byte per cycle while each byte yields at most one token and
// out_ready is high; a byte that yields two or three tokens holds in_ready low
// until the three-entry result buffer is down to its last token.
// Reset (rst_n low, synchronous): idle, offset 0, line 1, buffer empty.
// ----------------------------------------------------------------------------
// script_token_lexer
// Streaming lexer: one source byte per beat in, tokens out one per beat.
// ----------------------------------------------------------------------------
`include "script_token_lexer_defines.svh"

module script_token_lexer #(
  parameter int POSITION_BITS = 16,
  parameter int LINE_BITS     = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  stl_pkg::stl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output stl_pkg::stl_tok_t out_data
);
  import stl_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;
  localparam logic [LINE_BITS-1:0]     LINE_MAX = '1;

  stl_mode_t               mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, begin_r, begin_nxt;
  logic [LINE_BITS-1:0]     line_r, line_nxt;
  logic [7:0]               held_r, held_nxt;
  logic [7:0]               prefix_r [PREFIX_DEPTH];
  logic                     pre_we;
  logic [2:0]               pre_idx;

  stl_tok_t   buf_r [3];
  logic [1:0] rd_r, cnt_r;
  stl_tok_t   toks [3];
  logic [1:0] n;

  logic in_fire, out_fire;
  logic [POSITION_BITS-1:0] pos, nxt, dot, idx;
  logic [7:0] c;
  logic       eos, fresh;

  function automatic logic [15:0] clamp_pos(input logic [POSITION_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'd65535) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [15:0] clamp_line(input logic [LINE_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'd65535) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic stl_tok_t mk(input logic [5:0] k,
                                  input logic [POSITION_BITS-1:0] b,
                                  input logic [POSITION_BITS-1:0] e,
                                  input logic [1:0] er,
                                  input logic [LINE_BITS-1:0] ln);
    stl_tok_t t;
    t.token_kind   = k;
    t.start_offset = clamp_pos(b);
    t.token_length = clamp_pos((e >= b) ? e - b : '0);
    t.line_number  = clamp_line(ln);
    t.error_kind   = er;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  // handshake
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = buf_r[rd_r];
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign in_fire   = in_valid && in_ready;

  // lexing of one beat
  always_comb begin
    c        = in_data.char_code;
    eos      = in_data.end_of_source;
    pos      = pos_r;
    nxt      = (pos_r < POS_MAX) ? pos_r + 1'b1 : pos_r;
    dot      = (pos_r != '0) ? pos_r - 1'b1 : '0;
    idx      = pos_r - begin_r;
    fresh    = 1'b1;
    mode_nxt = mode_r;
    begin_nxt = begin_r;
    line_nxt = line_r;
    held_nxt = held_r;
    pos_nxt  = pos_r;
    pre_we   = 1'b0;
    pre_idx  = idx[2:0];
    n        = 2'd0;
    for (int i = 0; i < 3; i++) toks[i] = mk(K_EOF, '0, '0, E_NONE, line_r);

    // continue the pending token
    if (!eos) begin
      unique case (mode_r)
        M_IDENT: if (is_alpha(c) || is_digit(c)) begin
          if (idx < POSITION_BITS'(PREFIX_DEPTH)) pre_we = 1'b1;
          fresh = 1'b0;
        end
        M_NUMBER: if (is_digit(c)) fresh = 1'b0;
          else if (c == ".") begin
            mode_nxt = M_NUM_DOT; held_nxt = "."; fresh = 1'b0;
          end
        M_NUM_DOT: if (is_digit(c)) begin mode_nxt = M_FRACTION; fresh = 1'b0; end
        M_FRACTION: if (is_digit(c)) fresh = 1'b0;
        M_STRING: begin
          fresh = 1'b0;
          if (c == "\"") begin
            toks[n] = mk(K_STRING, begin_r, nxt, E_NONE, line_r); n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else if (c == "\n" && line_r < LINE_MAX) line_nxt = line_r + 1'b1;
        end
        M_HELD_OP: if (c == "=") begin
          toks[n] = mk(op_kind(held_r, 1'b1), begin_r, nxt, E_NONE, line_r);
          n = n + 2'd1;
          mode_nxt = M_IDLE; fresh = 1'b0;
        end
        M_HELD_SLASH: if (c == "/") begin mode_nxt = M_COMMENT; fresh = 1'b0; end
        M_COMMENT: begin
          fresh = 1'b0;
          if (c == "\n") begin
            if (line_r < LINE_MAX) line_nxt = line_r + 1'b1;
            mode_nxt = M_IDLE;
          end
        end
        default: ;
      endcase
      pos_nxt = nxt;
    end

    // close the pending token
    if (eos || fresh) begin
      unique case (mode_r) inside
        M_IDENT: begin
          toks[n] = mk((idx > POSITION_BITS'(PREFIX_DEPTH)) ? K_IDENT
                       : word_kind(prefix_r, idx[2:0]), begin_r, pos, E_NONE, line_r);
          n = n + 2'd1;
        end
        M_NUMBER, M_FRACTION: begin
          toks[n] = mk(K_NUMBER, begin_r, pos, E_NONE, line_r); n = n + 2'd1;
        end
        M_NUM_DOT: begin
          toks[n] = mk(K_NUMBER, begin_r, dot, E_NONE, line_r); n = n + 2'd1;
          toks[n] = mk(K_DOT, dot, pos, E_NONE, line_r); n = n + 2'd1;
        end
        M_STRING: begin
          toks[n] = mk(K_ERROR, begin_r, pos, E_UNTERM, line_r); n = n + 2'd1;
        end
        M_HELD_OP: begin
          toks[n] = mk(op_kind(held_r, 1'b0), begin_r, pos, E_NONE, line_r);
          n = n + 2'd1;
        end
        M_HELD_SLASH: begin
          toks[n] = mk(K_SLASH, begin_r, pos, E_NONE, line_r); n = n + 2'd1;
        end
        default: ;
      endcase
      mode_nxt = M_IDLE;
    end

    // end of file, or start of a new token
    if (eos) begin
      toks[n] = mk(K_EOF, pos, pos, E_NONE, line_r); n = n + 2'd1;
    end else if (fresh) begin
      begin_nxt = pos;
      if (is_alpha(c)) begin
        mode_nxt = M_IDENT; pre_we = 1'b1; pre_idx = 3'd0;
      end else if (is_digit(c)) begin
        mode_nxt = M_NUMBER;
      end else begin
        case (c) inside
          " ", "\r", "\t": ;
          "\n": if (line_r < LINE_MAX) line_nxt = line_r + 1'b1;
          "(": begin toks[n] = mk(K_LPAREN, pos, nxt, E_NONE, line_r); n = n + 2'd1; end
          ")": begin toks[n] = mk(K_RPAREN, pos, nxt, E_NONE, line_r); n = n + 2'd1; end
          "{": begin toks[n] = mk(K_LBRACE, pos, nxt, E_NONE, line_r); n = n + 2'd1; end
          "}": begin toks[n] = mk(K_RBRACE, pos, nxt, E_NONE, line_r); n = n + 2'd1; end
          ",": begin toks[n] = mk(K_COMMA, pos, nxt, E_NONE, line_r); n = n + 2'd1; end
          ".": begin toks[n] = mk(K_DOT, pos, nxt, E_NONE, line_r); n = n + 2'd1; end
          "-": begin toks[n] = mk(K_MINUS, pos, nxt, E_NONE, line_r); n = n + 2'd1; end
          "+": begin toks[n] = mk(K_PLUS, pos, nxt, E_NONE, line_r); n = n + 2'd1; end
          ";": begin toks[n] = mk(K_SEMI, pos, nxt, E_NONE, line_r); n = n + 2'd1; end
          "*": begin toks[n] = mk(K_STAR, pos, nxt, E_NONE, line_r); n = n + 2'd1; end
          "/": begin mode_nxt = M_HELD_SLASH; held_nxt = "/"; end
          "!", "=", "<", ">": begin mode_nxt = M_HELD_OP; held_nxt = c; end
          "\"": mode_nxt = M_STRING;
          default: begin
            toks[n] = mk(K_ERROR, pos, nxt, E_CHAR, line_r); n = n + 2'd1;
          end
        endcase
      end
    end

    // mark the final token of the run
    if (n != 2'd0) toks[n - 2'd1].last_of_run = 1'b1;
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      pos_r   <= '0;
      begin_r <= '0;
      line_r  <= LINE_BITS'(1);
      held_r  <= 8'h00;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      begin_r <= begin_nxt;
      line_r  <= line_nxt;
      held_r  <= held_nxt;
    end
  end

  // word prefix store
  always_ff @(posedge clk) begin
    if (in_fire && pre_we) prefix_r[pre_idx] <= c;
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 2'd0;
      cnt_r <= 2'd0;
    end else if (in_fire) begin
      rd_r  <= 2'd0;
      cnt_r <= n;
    end else if (out_fire) begin
      rd_r  <= rd_r + 2'd1;
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < 3; i++) buf_r[i] <= toks[i];
    end
  end

  // checks
  `STL_ASSERT_ALWAYS(a_cnt_range, cnt_r <= 2'd3)
  `STL_ASSERT_ALWAYS(a_last_mark, !(out_valid && cnt_r == 2'd1) || out_data.last_of_run)
  `STL_ASSERT_ALWAYS(a_ready_room, !in_ready || cnt_r <= 2'd1)
  `STL_ASSERT_NEXT(a_pos_mono, in_fire, pos_r >= $past(pos_r))

endmodule

[sim/script_token_lexer_tb.sv]
// ----------------------------------------------------------------------------
// script_token_lexer_tb
// Feeds source bytes and end markers into the lexer and checks every token
// against a behavioural scanner kept in the bench, with random idling on
// both channels and a long output stall.
// ----------------------------------------------------------------------------
module script_token_lexer_tb;
  import stl_pkg::*;

  localparam int POS_MAX  = 16'hFFFF;
  localparam int LINE_MAX = 16'hFFFF;
  localparam int WATCHDOG = 20000;

  typedef enum int {
    S_IDLE, S_IDENT, S_NUMBER, S_NUM_DOT, S_FRACTION,
    S_STRING, S_HELD_OP, S_HELD_SLASH, S_COMMENT
  } scan_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  stl_in_t   in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  stl_tok_t  out_data;

  script_token_lexer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // scanner state of the bench
  scan_t      sc_mode;
  int         sc_pos;
  int         sc_begin;
  int         sc_line;
  logic [7:0] sc_held;
  logic [7:0] sc_word [PREFIX_DEPTH];

  stl_in_t  src_q [$];
  stl_tok_t token_q [$];
  stl_tok_t step_toks [$];

  int errors = 0;
  int bytes_sent = 0;
  int tokens_seen = 0;
  int idle_cycles = 0;
  logic hold_out = 1'b0;
  logic pause_in = 1'b0;

  localparam string KW_TEXT [16] = '{"and", "class", "else", "false", "for", "fun",
    "if", "nil", "or", "print", "return", "super", "this", "true", "var", "while"};

  function automatic logic alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void push_tok(logic [5:0] kind, int b, int e, logic [1:0] err);
    stl_tok_t t;
    t.token_kind   = kind;
    t.start_offset = 16'(b > 65535 ? 65535 : b);
    t.token_length = 16'(e >= b ? e - b : 0);
    t.line_number  = 16'(sc_line);
    t.error_kind   = err;
    t.last_of_run  = 1'b0;
    if (step_toks.size() < 3) step_toks.push_back(t);
  endfunction

  function automatic logic [5:0] classify_word(int len);
    logic ok;
    if (len > PREFIX_DEPTH) return K_IDENT;
    for (int k = 0; k < 16; k++) begin
      if (KW_TEXT[k].len() == len) begin
        ok = 1'b1;
        for (int i = 0; i < len; i++)
          if (sc_word[i] != KW_TEXT[k][i]) ok = 1'b0;
        if (ok) return K_KW_BASE + 6'(k);
      end
    end
    return K_IDENT;
  endfunction

  function automatic logic [5:0] cmp_kind(logic [7:0] c, logic two);
    logic [5:0] b;
    b = (c == "=") ? K_EQUAL : (c == ">") ? K_GREATER : (c == "<") ? K_LESS : K_BANG;
    return two ? b + 6'd1 : b;
  endfunction

  function automatic void close_pending(int p);
    int d;
    d = p > 0 ? p - 1 : 0;
    case (sc_mode)
      S_IDENT:      push_tok(classify_word(p - sc_begin), sc_begin, p, E_NONE);
      S_NUMBER, S_FRACTION: push_tok(K_NUMBER, sc_begin, p, E_NONE);
      S_NUM_DOT: begin
        push_tok(K_NUMBER, sc_begin, d, E_NONE);
        push_tok(K_DOT, d, p, E_NONE);
      end
      S_STRING:     push_tok(K_ERROR, sc_begin, p, E_UNTERM);
      S_HELD_OP:    push_tok(cmp_kind(sc_held, 1'b0), sc_begin, p, E_NONE);
      S_HELD_SLASH: push_tok(K_SLASH, sc_begin, p, E_NONE);
      default: ;
    endcase
    sc_mode = S_IDLE;
  endfunction

  function automatic void bump_line();
    if (sc_line < LINE_MAX) sc_line++;
  endfunction

  function automatic void open_token(logic [7:0] c, int p, int n);
    sc_mode  = S_IDLE;
    sc_begin = p;
    if (alpha_c(c)) begin
      sc_mode = S_IDENT;
      sc_word[0] = c;
    end else if (digit_c(c)) begin
      sc_mode = S_NUMBER;
    end else begin
      case (c)
        " ", 8'h0d, 8'h09: ;
        8'h0a: bump_line();
        "(": push_tok(K_LPAREN, p, n, E_NONE);
        ")": push_tok(K_RPAREN, p, n, E_NONE);
        "{": push_tok(K_LBRACE, p, n, E_NONE);
        "}": push_tok(K_RBRACE, p, n, E_NONE);
        ",": push_tok(K_COMMA, p, n, E_NONE);
        ".": push_tok(K_DOT, p, n, E_NONE);
        "-": push_tok(K_MINUS, p, n, E_NONE);
        "+": push_tok(K_PLUS, p, n, E_NONE);
        ";": push_tok(K_SEMI, p, n, E_NONE);
        "*": push_tok(K_STAR, p, n, E_NONE);
        "/": begin
          sc_mode = S_HELD_SLASH;
          sc_held = c;
        end
        "!", "=", "<", ">": begin
          sc_mode = S_HELD_OP;
          sc_held = c;
        end
        "\"": sc_mode = S_STRING;
        default: push_tok(K_ERROR, p, n, E_CHAR);
      endcase
    end
  endfunction

  // work out the tokens one accepted beat causes
  function automatic void scan_beat(stl_in_t b);
    logic [7:0] c;
    int p, n;
    logic fresh;
    c = b.char_code;
    p = sc_pos;
    n = p < POS_MAX ? p + 1 : p;
    fresh = 1'b1;
    step_toks.delete();
    if (b.end_of_source) begin
      close_pending(p);
      push_tok(K_EOF, p, p, E_NONE);
    end else begin
      case (sc_mode)
        S_IDENT: if (alpha_c(c) || digit_c(c)) begin
          if (p - sc_begin < PREFIX_DEPTH) sc_word[p - sc_begin] = c;
          fresh = 1'b0;
        end
        S_NUMBER: if (digit_c(c)) fresh = 1'b0;
          else if (c == ".") begin
            sc_mode = S_NUM_DOT;
            sc_held = c;
            fresh = 1'b0;
          end
        S_NUM_DOT: if (digit_c(c)) begin
          sc_mode = S_FRACTION;
          fresh = 1'b0;
        end
        S_FRACTION: if (digit_c(c)) fresh = 1'b0;
        S_STRING: begin
          fresh = 1'b0;
          if (c == "\"") begin
            push_tok(K_STRING, sc_begin, n, E_NONE);
            sc_mode = S_IDLE;
          end else if (c == 8'h0a) bump_line();
        end
        S_HELD_OP: if (c == "=") begin
          push_tok(cmp_kind(sc_held, 1'b1), sc_begin, n, E_NONE);
          sc_mode = S_IDLE;
          fresh = 1'b0;
        end
        S_HELD_SLASH: if (c == "/") begin
          sc_mode = S_COMMENT;
          fresh = 1'b0;
        end
        S_COMMENT: begin
          fresh = 1'b0;
          if (c == 8'h0a) begin
            bump_line();
            sc_mode = S_IDLE;
          end
        end
        default: ;
      endcase
      if (fresh) begin
        close_pending(p);
        open_token(c, p, n);
      end
      sc_pos = n;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last_of_run = 1'b1;
    foreach (step_toks[i]) token_q.push_back(step_toks[i]);
  endfunction

  // stimulus helpers
  function automatic void add_byte(logic [7:0] c);
    stl_in_t b;
    b.char_code = c;
    b.end_of_source = 1'b0;
    src_q.push_back(b);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_end(logic [7:0] junk);
    stl_in_t b;
    b.char_code = junk;
    b.end_of_source = 1'b1;
    src_q.push_back(b);
  endfunction

  localparam string FRAGS [24] = '{"and", "class", "else", "false", "for", "fun",
    "if", "nil", "or", "print", "return", "super", "this", "true", "var", "while",
    "x_1", "returns", "Foo", "12.5", "7.", "\"s\\n\"", "// c\n", "!= <= >= =="};
  localparam string SYMS = "(){},.-+;*/!=<> \n\t\r\"_aZ09.";

  function automatic void add_random_chunk();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) add_text(FRAGS[$urandom_range(0, 23)]);
    else if (r < 9) add_byte(SYMS[$urandom_range(0, SYMS.len() - 1)]);
    else add_byte(8'($urandom()));
  endfunction

  // driver
  int in_wait = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        scan_beat(in_data);
        bytes_sent++;
        in_wait = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) in_wait = 0;
      end
      if (!(in_valid && !in_ready)) begin
        if (in_wait > 0 || pause_in || src_q.size() == 0) begin
          if (in_wait > 0) in_wait--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= src_q.pop_front();
        end
      end
    end
  end

  // monitor and receiver idling
  int out_wait = 0;
  stl_tok_t want;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        tokens_seen++;
        if (token_q.size() == 0) begin
          $error("unexpected token kind %0d", out_data.token_kind);
          errors++;
        end else begin
          want = token_q.pop_front();
          if (out_data.token_kind !== want.token_kind) begin
            $error("token_kind expected %0d got %0d", want.token_kind, out_data.token_kind);
            errors++;
          end
          if (out_data.start_offset !== want.start_offset) begin
            $error("start_offset expected %0d got %0d", want.start_offset,
                   out_data.start_offset);
            errors++;
          end
          if (out_data.token_length !== want.token_length) begin
            $error("token_length expected %0d got %0d", want.token_length,
                   out_data.token_length);
            errors++;
          end
          if (out_data.line_number !== want.line_number) begin
            $error("line_number expected %0d got %0d", want.line_number,
                   out_data.line_number);
            errors++;
          end
          if (out_data.error_kind !== want.error_kind) begin
            $error("error_kind expected %0d got %0d", want.error_kind, out_data.error_kind);
            errors++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $error("last_of_run expected %0d got %0d", want.last_of_run,
                   out_data.last_of_run);
            errors++;
          end
        end
        out_wait = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) out_wait = 0;
      end
      if (out_wait > 0 || hold_out) begin
        if (out_wait > 0) out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    sc_mode = S_IDLE;
    sc_pos = 0;
    sc_begin = 0;
    sc_line = 1;
    sc_held = 8'h00;
    foreach (sc_word[i]) sc_word[i] = 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: operators, keywords, literals, errors, comments
    add_text("(){},.-+;*!!=a==b<c<=d>e>=f/g//x\n");
    add_text("and class else false for fun if nil or print return super this true var while");
    add_text(" 12.5 7.x 3. \"ab\ncd\" _Zz9 \t\r");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h80);
    add_text("<");
    add_end(8'hFF);
    add_text("\"open");
    add_end(8'h00);
    add_text("9.");
    add_end(8'h55);

    // random: mostly well-formed fragments, a little noise
    for (int i = 0; i < 90; i++) begin
      add_random_chunk();
      if ($urandom_range(0, 3) == 0) add_byte(" ");
      if ($urandom_range(0, 40) == 0) add_end(8'($urandom()));
    end
    add_end(8'h00);

    // long output stall while bytes keep coming
    wait (src_q.size() < 300);
    hold_out <= 1'b1;
    repeat (200) @(posedge clk);
    hold_out <= 1'b0;

    // sender pause until the pipe drains
    wait (src_q.size() < 100);
    pause_in <= 1'b1;
    wait (token_q.size() == 0 && !in_valid);
    repeat (4) @(posedge clk);
    pause_in <= 1'b0;

    wait (src_q.size() == 0 && !in_valid);
    wait (token_q.size() == 0);
    repeat (20) @(posedge clk);
    $display("lexed %0d bytes and end markers, checked %0d tokens", bytes_sent, tokens_seen);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
